### rtl/core/svae_pkg.sv
package svae_pkg;

	// Field and state widths
	localparam int OSC_W         = 32;
	localparam int OSC_FRAC_BITS = 30;
	localparam int GAIN_W        = 26;
	localparam int SAMPLE_W      = 24;
	localparam int REG_W         = 24;
	localparam int COUNT_BITS    = 24;
	localparam int CFG_IDX_W     = 3;

	// Command opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_SAMPLES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_SAMPLES   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SAMPLES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP    = 3'd5;

	// Register reset values
	localparam logic [REG_W-1:0] RST_ATTACK_SAMPLES  = 24'd480;
	localparam logic [REG_W-1:0] RST_DECAY_SAMPLES   = 24'd2400;
	localparam logic [REG_W-1:0] RST_RELEASE_SAMPLES = 24'd2400;
	localparam logic [REG_W-1:0] RST_ATTACK_STEP     = 24'd17476;
	localparam logic [REG_W-1:0] RST_DECAY_STEP      = 24'd1398;
	localparam logic [REG_W-1:0] RST_RELEASE_STEP    = 24'd2097;

endpackage

### rtl/core/svae_if.sv
// Command channel: start a note or tick one sample
interface svae_cmd_if import svae_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    opcode;
	logic signed [OSC_W-1:0] osc_coefficient;
	logic signed [OSC_W-1:0] first_value;
	logic [REG_W-1:0]        note_length;

	modport source (output valid, output opcode, output osc_coefficient,
		output first_value, output note_length, input ready);
	modport sink (input valid, input opcode, input osc_coefficient,
		input first_value, input note_length, output ready);
endinterface

// Result channel: one enveloped sample per tick
interface svae_res_if import svae_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_of_note;
	logic                       idle;

	modport source (output valid, output sample, output last_of_note, output idle,
		input ready);
	modport sink (input valid, input sample, input last_of_note, input idle,
		output ready);
endinterface

// Configuration write channel
interface svae_cfg_if import svae_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [REG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/sine_voice_with_adsr_envelope.sv
// Channel  | Role   | Payload
// ---------+--------+-------------------------------------------------------
// cmd      | sink   | opcode, osc_coefficient, first_value, note_length
// result   | source | sample, last_of_note, idle (one item per tick)
// cfg      | sink   | index, data (register write, always ready)
//
// One item per cycle: each command is worked in the cycle it is accepted, with
// the oscillator recurrence and the gain product side by side in front of the
// voice state and the result register. A tick shows its result in the next
// cycle. arst_n clears the voice state and result valid and loads the register
// defaults. cmd stalls only while the result register is full and not taken.
module sine_voice_with_adsr_envelope import svae_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	svae_cmd_if.sink    cmd,
	svae_res_if.source  result,
	svae_cfg_if.sink    cfg
);

	localparam int SPROD_W = OSC_W + GAIN_W + 1;
	localparam int OPROD_W = 2 * OSC_W + 1;
	localparam int GSUM_W  = GAIN_W + 2;
	localparam int CMP_W   = COUNT_BITS + REG_W;

	localparam logic signed [SPROD_W-1:0] S_HALF = SPROD_W'(1) << (OSC_FRAC_BITS - 1);
	localparam logic signed [OPROD_W-1:0] O_HALF = OPROD_W'(1) << (OSC_FRAC_BITS - 1);

	// Configuration registers
	logic [REG_W-1:0] attack_samples_q, decay_samples_q, release_samples_q;
	logic [REG_W-1:0] attack_step_q, decay_step_q, release_step_q;

	// Voice state
	logic signed [OSC_W-1:0]  osc_previous_q, osc_current_q, osc_alpha_q;
	logic signed [GAIN_W-1:0] env_gain_q;
	logic [COUNT_BITS-1:0]    sample_count_q;
	logic [REG_W-1:0]         length_left_q;

	// Result register
	logic                       res_valid_q;
	logic signed [SAMPLE_W-1:0] res_sample_q;
	logic                       res_last_q;
	logic                       res_idle_q;

	logic cmd_fire;
	logic note_active;

	logic signed [SPROD_W-1:0]  sprod, sround, sshift;
	logic                       sample_fits;
	logic signed [SAMPLE_W-1:0] sample_sat;

	logic signed [OPROD_W-1:0] oprod, oround, oshift, onext;
	logic                      osc_fits;
	logic signed [OSC_W-1:0]   osc_sat;

	logic                     in_release, in_attack, in_decay;
	logic signed [GSUM_W-1:0] gain_base, gsum;
	logic                     gain_fits;
	logic signed [GAIN_W-1:0] gain_sat;

	assign cmd.ready   = !res_valid_q || result.ready;
	assign cmd_fire    = cmd.valid && cmd.ready;
	assign note_active = (length_left_q != '0);
	assign cfg.ready   = 1'b1;

	assign result.valid        = res_valid_q;
	assign result.sample       = res_sample_q;
	assign result.last_of_note = res_last_q;
	assign result.idle         = res_idle_q;

	// Output sample: previous oscillator value times gain, rounded and saturated
	always_comb begin
		sprod       = SPROD_W'(osc_previous_q) * SPROD_W'(env_gain_q);
		sround      = sprod + S_HALF;
		sshift      = sround >>> OSC_FRAC_BITS;
		sample_fits = (&sshift[SPROD_W-1:SAMPLE_W-1]) || !(|sshift[SPROD_W-1:SAMPLE_W-1]);
		if (sample_fits) begin
			sample_sat = sshift[SAMPLE_W-1:0];
		end else if (sshift[SPROD_W-1]) begin
			sample_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			sample_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	// Oscillator recurrence: alpha * current - previous, saturated
	always_comb begin
		oprod    = OPROD_W'(osc_alpha_q) * OPROD_W'(osc_current_q);
		oround   = oprod + O_HALF;
		oshift   = oround >>> OSC_FRAC_BITS;
		onext    = oshift - OPROD_W'(osc_previous_q);
		osc_fits = (&onext[OPROD_W-1:OSC_W-1]) || !(|onext[OPROD_W-1:OSC_W-1]);
		if (osc_fits) begin
			osc_sat = onext[OSC_W-1:0];
		end else if (onext[OPROD_W-1]) begin
			osc_sat = {1'b1, {(OSC_W-1){1'b0}}};
		end else begin
			osc_sat = {1'b0, {(OSC_W-1){1'b1}}};
		end
	end

	// Envelope: release covers the tail of the note, then attack, decay, sustain
	always_comb begin
		in_release = (length_left_q <= release_samples_q);
		in_attack  = (CMP_W'(sample_count_q) < CMP_W'(attack_samples_q));
		in_decay   = (CMP_W'(sample_count_q) <
			(CMP_W'(attack_samples_q) + CMP_W'(decay_samples_q)));
		gain_base  = GSUM_W'(env_gain_q);
		if (in_release) begin
			gsum = gain_base - GSUM_W'(release_step_q);
		end else if (in_attack) begin
			gsum = gain_base + GSUM_W'(attack_step_q);
		end else if (in_decay) begin
			gsum = gain_base - GSUM_W'(decay_step_q);
		end else begin
			gsum = gain_base;
		end
		gain_fits = (&gsum[GSUM_W-1:GAIN_W-1]) || !(|gsum[GSUM_W-1:GAIN_W-1]);
		if (gain_fits) begin
			gain_sat = gsum[GAIN_W-1:0];
		end else if (gsum[GSUM_W-1]) begin
			gain_sat = {1'b1, {(GAIN_W-1){1'b0}}};
		end else begin
			gain_sat = {1'b0, {(GAIN_W-1){1'b1}}};
		end
	end

	// Configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_samples_q  <= RST_ATTACK_SAMPLES;
			decay_samples_q   <= RST_DECAY_SAMPLES;
			release_samples_q <= RST_RELEASE_SAMPLES;
			attack_step_q     <= RST_ATTACK_STEP;
			decay_step_q      <= RST_DECAY_STEP;
			release_step_q    <= RST_RELEASE_STEP;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ATTACK_SAMPLES:  attack_samples_q  <= cfg.data;
				REG_DECAY_SAMPLES:   decay_samples_q   <= cfg.data;
				REG_RELEASE_SAMPLES: release_samples_q <= cfg.data;
				REG_ATTACK_STEP:     attack_step_q     <= cfg.data;
				REG_DECAY_STEP:      decay_step_q      <= cfg.data;
				REG_RELEASE_STEP:    release_step_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// Voice state: a start loads the note, a tick in an active note advances it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_previous_q <= '0;
			osc_current_q  <= '0;
			osc_alpha_q    <= '0;
			env_gain_q     <= '0;
			sample_count_q <= '0;
			length_left_q  <= '0;
		end else if (cmd_fire) begin
			if (cmd.opcode == OP_START) begin
				osc_alpha_q    <= cmd.osc_coefficient;
				osc_current_q  <= cmd.first_value;
				osc_previous_q <= '0;
				env_gain_q     <= '0;
				sample_count_q <= '0;
				length_left_q  <= cmd.note_length;
			end else if (note_active) begin
				osc_previous_q <= osc_current_q;
				osc_current_q  <= osc_sat;
				env_gain_q     <= gain_sat;
				if (sample_count_q != '1) begin
					sample_count_q <= sample_count_q + 1'b1;
				end
				length_left_q  <= length_left_q - 1'b1;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_fire && cmd.opcode == OP_TICK) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload; an idle voice gives a zero sample
	always_ff @(posedge clk) begin
		if (cmd_fire && cmd.opcode == OP_TICK) begin
			if (note_active) begin
				res_sample_q <= sample_sat;
				res_last_q   <= (length_left_q == REG_W'(1));
				res_idle_q   <= 1'b0;
			end else begin
				res_sample_q <= '0;
				res_last_q   <= 1'b0;
				res_idle_q   <= 1'b1;
			end
		end
	end

endmodule
